>>> rtl/nsc_pkg.sv
// Shared types, character codes and helper functions of the NMEA sentence checker.
package nsc_pkg;

    localparam int LenWidth   = 8;
    localparam int OutCountW  = 16;
    localparam int NumTalkers = 5;
    localparam int HeadDepth  = 6;
    localparam int TailDepth  = 3;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChDigit0 = 8'h30;
    localparam logic [7:0] ChDigit9 = 8'h39;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperF = 8'h46;
    localparam logic [7:0] HexAlpha = 8'h37;

    typedef enum logic [2:0]
    {
        ST_ACCEPTED = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NO_START = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_OVERLONG = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        CN_GPS     = 3'd0,
        CN_GALILEO = 3'd1,
        CN_GLONASS = 3'd2,
        CN_BEIDOU  = 3'd3,
        CN_UNKNOWN = 3'd4
    } cons_t;

    typedef enum logic [2:0]
    {
        SK_GLL   = 3'd0,
        SK_GGA   = 3'd1,
        SK_GSA   = 3'd2,
        SK_GSV   = 3'd3,
        SK_VTG   = 3'd4,
        SK_TXT   = 3'd5,
        SK_OTHER = 3'd6
    } kind_t;

    typedef struct packed
    {
        logic                accept;
        status_t             status;
        cons_t               constellation;
        kind_t               sentence_kind;
        logic [LenWidth-1:0] line_length;
        logic [7:0]          computed_sum;
        logic [7:0]          received_sum;
    } line_eval_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c >= ChDigit0 && c <= ChDigit9)
            begin
                diff = c - ChDigit0;
            end
            else if (c >= ChUpperA && c <= ChUpperF)
            begin
                diff = c - HexAlpha;
            end
            return diff[3:0];
        end
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == ChCr) || (c == ChLf);
    endfunction

endpackage

>>> rtl/nsc_line_tracker.sv
// Line state of the checker: length, tail window, running XOR, head characters and evaluation.
module nsc_line_tracker #(
    parameter int MAX_LINE = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_char,
    output nsc_pkg::line_eval_t eval
);

    localparam logic [nsc_pkg::LenWidth-1:0] MaxLen = nsc_pkg::LenWidth'(MAX_LINE);

    logic [nsc_pkg::LenWidth-1:0] len_reg, len_next, base_len;
    logic [7:0] xor_reg, xor_next, base_xor;
    logic [7:0] win_reg  [nsc_pkg::TailDepth];
    logic [7:0] win_next [nsc_pkg::TailDepth];
    logic [7:0] head_reg  [nsc_pkg::HeadDepth];
    logic [7:0] head_next [nsc_pkg::HeadDepth];
    logic       is_dollar;
    logic [7:0] recv;
    nsc_pkg::cons_t talker;
    nsc_pkg::kind_t kind;

    assign recv = {nsc_pkg::hex_value(win_reg[1]), nsc_pkg::hex_value(win_reg[2])};

    always_comb
    begin
        talker = nsc_pkg::CN_UNKNOWN;
        if (head_reg[1] == "G")
        begin
            unique case (head_reg[2])
                "P":     talker = nsc_pkg::CN_GPS;
                "A":     talker = nsc_pkg::CN_GALILEO;
                "L":     talker = nsc_pkg::CN_GLONASS;
                "B":     talker = nsc_pkg::CN_BEIDOU;
                default: talker = nsc_pkg::CN_UNKNOWN;
            endcase
        end
    end

    always_comb
    begin
        unique case ({head_reg[3], head_reg[4], head_reg[5]})
            "GLL":   kind = nsc_pkg::SK_GLL;
            "GGA":   kind = nsc_pkg::SK_GGA;
            "GSA":   kind = nsc_pkg::SK_GSA;
            "GSV":   kind = nsc_pkg::SK_GSV;
            "VTG":   kind = nsc_pkg::SK_VTG;
            "TXT":   kind = nsc_pkg::SK_TXT;
            default: kind = nsc_pkg::SK_OTHER;
        endcase
    end

    always_comb
    begin
        eval.line_length  = len_reg;
        eval.computed_sum = xor_reg;
        eval.received_sum = recv;
        priority if (len_reg == '0)
            eval.status = nsc_pkg::ST_EMPTY;
        else if (head_reg[0] != nsc_pkg::ChDollar)
            eval.status = nsc_pkg::ST_NO_START;
        else if (len_reg >= MaxLen)
            eval.status = nsc_pkg::ST_OVERLONG;
        else if (len_reg < nsc_pkg::LenWidth'(4) || win_reg[0] != nsc_pkg::ChStar ||
                 xor_reg != recv)
            eval.status = nsc_pkg::ST_MISMATCH;
        else
            eval.status = nsc_pkg::ST_ACCEPTED;
        eval.accept        = (eval.status == nsc_pkg::ST_ACCEPTED);
        eval.constellation = eval.accept ? talker : nsc_pkg::CN_GPS;
        eval.sentence_kind = eval.accept ? kind : nsc_pkg::SK_GLL;
    end

    assign is_dollar = (rx_char == nsc_pkg::ChDollar);

    always_comb
    begin
        len_next  = len_reg;
        xor_next  = xor_reg;
        win_next  = win_reg;
        head_next = head_reg;
        base_len  = is_dollar ? '0 : len_reg;
        base_xor  = is_dollar ? 8'h00 : xor_reg;
        if (step)
        begin
            if (nsc_pkg::is_line_end(rx_char))
            begin
                if (eval.accept)
                begin
                    len_next = '0;
                    xor_next = 8'h00;
                    for (int i = 0; i < nsc_pkg::HeadDepth; i++)
                    begin
                        head_next[i] = 8'h00;
                    end
                end
            end
            else
            begin
                len_next = base_len;
                xor_next = base_xor;
                for (int i = 0; i < nsc_pkg::HeadDepth; i++)
                begin
                    head_next[i] = is_dollar ? 8'h00 : head_reg[i];
                end
                if (base_len < MaxLen)
                begin
                    for (int i = 0; i < nsc_pkg::HeadDepth; i++)
                    begin
                        if (base_len == nsc_pkg::LenWidth'(i))
                        begin
                            head_next[i] = rx_char;
                        end
                    end
                    if (base_len >= nsc_pkg::LenWidth'(4))
                    begin
                        xor_next = base_xor ^ win_reg[0];
                    end
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = rx_char;
                    len_next    = base_len + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            xor_reg <= 8'h00;
            for (int i = 0; i < nsc_pkg::TailDepth; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            for (int i = 0; i < nsc_pkg::HeadDepth; i++)
            begin
                head_reg[i] <= 8'h00;
            end
        end
        else
        begin
            len_reg  <= len_next;
            xor_reg  <= xor_next;
            win_reg  <= win_next;
            head_reg <= head_next;
        end
    end

endmodule

>>> rtl/nsc_msg_counter.sv
// Wrapping per-constellation counters of accepted sentences.
module nsc_msg_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   bump,
    input  nsc_pkg::cons_t         constellation,
    output logic [COUNT_WIDTH-1:0] count_next
);

    logic [COUNT_WIDTH-1:0] counts_reg [nsc_pkg::NumTalkers];

    assign count_next = counts_reg[constellation] + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nsc_pkg::NumTalkers; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (bump)
        begin
            counts_reg[constellation] <= count_next;
        end
    end

endmodule

>>> rtl/nmea_sentence_checker.sv
// Top level of the NMEA 0183 sentence checker: input and result registers around the line logic.
//
//  Channel | Direction | Beat content (lowest bits first)
//  --------+-----------+-------------------------------------------------------------------
//  s_axis  | in        | rx_char[7:0]
//  m_axis  | out       | status, constellation, sentence_kind, line_length, computed_sum,
//          |           | received_sum, message_count, zero padding to 56 bits
//
// Each character is processed in the cycle it sits in the input register; the result of a line
// end is registered into the output register as that line end leaves the input register.
// One character can be accepted on every cycle while no line end is held. A stalled result
// only holds back a following line end; other characters keep flowing. Reset clears the line
// state and all constellation counters at once.
module nmea_sentence_checker #(
    parameter int MAX_LINE    = 128,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_char[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status[2:0], constellation[5:3], sentence_kind[8:6],
                                        // line_length[16:9], computed_sum[24:17],
                                        // received_sum[32:25], message_count[48:33]
);

    logic                           in_valid_reg;
    logic [7:0]                     in_char_reg;
    logic                           out_valid_reg;
    logic [55:0]                    out_data_reg;
    logic                           in_eol;
    logic                           advance;
    logic                           emit;
    nsc_pkg::line_eval_t            eval;
    logic [COUNT_WIDTH-1:0]         count_next;
    logic [nsc_pkg::OutCountW-1:0]  msg_count;

    assign in_eol  = nsc_pkg::is_line_end(in_char_reg);
    assign advance = in_valid_reg && (!in_eol || !out_valid_reg || m_axis_tready);
    assign emit    = advance && in_eol;

    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    nsc_line_tracker #(
        .MAX_LINE (MAX_LINE)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_char (in_char_reg),
        .eval    (eval)
    );

    nsc_msg_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .clk           (clk),
        .rst_n         (rst_n),
        .bump          (emit && eval.accept),
        .constellation (eval.constellation),
        .count_next    (count_next)
    );

    assign msg_count = eval.accept ? nsc_pkg::OutCountW'(count_next) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
        end
        if (emit)
        begin
            out_data_reg <= {7'b0, msg_count, eval.received_sum, eval.computed_sum,
                             eval.line_length, eval.sentence_kind, eval.constellation,
                             eval.status};
        end
    end

    // A rejected line carries no classification and no count.
    a_reject_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !eval.accept) |=> (m_axis_tdata[8:3] == 6'b0 && m_axis_tdata[48:33] == 16'h0))
        else $error("rejected line carries classification or count");

    // An accepted line is at least four characters long and its sums agree.
    a_accept_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && eval.accept) |=> (m_axis_tdata[16:9] >= 8'd4 &&
                                   m_axis_tdata[24:17] == m_axis_tdata[32:25]))
        else $error("accepted line with short length or differing sums");

    // An empty input register never blocks the slave side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but not ready");

    // A line end that cannot be emitted stays in the input register.
    a_eol_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_eol && out_valid_reg && !m_axis_tready) |=>
        (in_valid_reg && $stable(in_char_reg)))
        else $error("stalled line end was lost");

endmodule
